FILE: rtl/vzre_pkg.sv
// Shared types and constants for the voxel zero-run encoder.
// Used by the front, the command queue, the back and the top level.
`default_nettype none

package vzre_pkg;

    localparam int VALUE_W   = 8;
    localparam int COLOR_W   = 8;
    localparam int RUN_W     = 13;
    localparam int MINRUN_W  = 4;
    localparam int ZCNT_W    = 3;   // up to seven short-run zero pairs
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [RUN_W-1:0]    RUN_MAX       = 13'd8191;
    localparam logic [MINRUN_W-1:0] MIN_RUN_RESET = 4'd3;
    localparam logic [MINRUN_W-1:0] MIN_RUN_LOW   = 4'd2;
    localparam logic [MINRUN_W-1:0] MIN_RUN_HIGH  = 4'd8;

    localparam logic KIND_PAIR = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    // One classified item: an optional flush (run record or short zeros),
    // then an optional value/colour pair.
    typedef struct packed {
        logic                run;
        logic [ZCNT_W-1:0]   nzeros;
        logic [RUN_W-1:0]    run_len;
        logic                pair;
        logic [VALUE_W-1:0]  value;
        logic [COLOR_W-1:0]  color;
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/vzre_front.sv
// Front end: accepts voxels, counts zero runs and classifies each item
// into a queue command. Depends on vzre_pkg.
`default_nettype none

module vzre_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [vzre_pkg::MINRUN_W-1:0] i_cfg_wr_data,
    input  wire logic                          i_in_valid,
    input  wire logic [vzre_pkg::VALUE_W-1:0]  i_voxel_value,
    input  wire logic [vzre_pkg::COLOR_W-1:0]  i_voxel_color,
    input  wire logic                          i_end_of_chunk,
    input  wire logic                          i_q_full,
    output logic                               o_in_stall,
    output logic                               o_push,
    output vzre_pkg::t_cmd                     o_cmd
);

    logic [vzre_pkg::MINRUN_W-1:0] r_min_run;
    logic [vzre_pkg::RUN_W-1:0]    r_pending;
    logic [vzre_pkg::RUN_W-1:0]    n_pending;
    logic [vzre_pkg::MINRUN_W-1:0] limit;
    logic [vzre_pkg::RUN_W-1:0]    inc;
    logic [vzre_pkg::RUN_W-1:0]    flush_len;
    logic                          accept;
    logic                          is_zero;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign is_zero    = (i_voxel_value == '0);
    assign inc        = r_pending + 1'b1;

    // Clamp the configured minimum into its meaningful range
    always_comb begin
        if (r_min_run < vzre_pkg::MIN_RUN_LOW) begin
            limit = vzre_pkg::MIN_RUN_LOW;
        end else if (r_min_run > vzre_pkg::MIN_RUN_HIGH) begin
            limit = vzre_pkg::MIN_RUN_HIGH;
        end else begin
            limit = r_min_run;
        end
    end

    // Classify the item and work out the next pending count
    always_comb begin
        n_pending = r_pending;
        o_push    = 1'b0;
        flush_len = is_zero ? inc : r_pending;
        o_cmd.run     = (flush_len >= {{(vzre_pkg::RUN_W-vzre_pkg::MINRUN_W){1'b0}}, limit});
        o_cmd.nzeros  = o_cmd.run ? '0 : flush_len[vzre_pkg::ZCNT_W-1:0];
        o_cmd.run_len = flush_len;
        o_cmd.pair    = !is_zero;
        o_cmd.value   = i_voxel_value;
        o_cmd.color   = i_voxel_color;
        if (is_zero) begin
            // an empty flush leaves run clear and nzeros zero
            if (i_end_of_chunk || inc == vzre_pkg::RUN_MAX) begin
                o_push    = accept;
                n_pending = '0;
            end else begin
                n_pending = inc;
            end
        end else begin
            o_push    = accept;
            n_pending = '0;
            if (r_pending == '0) begin
                o_cmd.run = 1'b0;
            end
        end
    end

    // Hold the minimum run register and the pending zero count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_run <= vzre_pkg::MIN_RUN_RESET;
            r_pending <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_min_run <= i_cfg_wr_data;
            end
            if (accept) begin
                r_pending <= n_pending;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/vzre_cmd_fifo.sv
// Short command queue between the front and the back end.
// Depends on vzre_pkg.
`default_nettype none

module vzre_cmd_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire vzre_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output vzre_pkg::t_cmd      o_head
);

    vzre_pkg::t_cmd                r_mem [vzre_pkg::QDEPTH];
    logic [vzre_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [vzre_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [vzre_pkg::QCNT_W-1:0]   r_count;

    assign o_full  = (r_count == vzre_pkg::QCNT_W'(vzre_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Write the entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/vzre_back.sv
// Back end: expands queued commands into result records, one per cycle
// while the output is not stalled, into the output register. Depends on vzre_pkg.
`default_nettype none

module vzre_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_q_empty,
    input  wire vzre_pkg::t_cmd               i_head,
    output logic                              o_pop,
    input  wire logic                         i_out_stall,
    output logic                              o_out_valid,
    output logic                              o_record_kind,
    output logic [vzre_pkg::VALUE_W-1:0]      o_out_value,
    output logic [vzre_pkg::COLOR_W-1:0]      o_out_color,
    output logic [vzre_pkg::RUN_W-1:0]        o_run_length,
    output logic                              o_last_of_item
);

    logic                          r_valid;
    logic                          r_kind;
    logic [vzre_pkg::VALUE_W-1:0]  r_value;
    logic [vzre_pkg::COLOR_W-1:0]  r_color;
    logic [vzre_pkg::RUN_W-1:0]    r_len;
    logic                          r_last;
    logic [vzre_pkg::ZCNT_W-1:0]   r_idx;

    logic                          load;
    logic                          take;
    logic [vzre_pkg::ZCNT_W-1:0]   n_flush;
    logic                          in_flush;
    logic                          n_kind;
    logic [vzre_pkg::VALUE_W-1:0]  n_value;
    logic [vzre_pkg::COLOR_W-1:0]  n_color;
    logic [vzre_pkg::RUN_W-1:0]    n_len;
    logic                          n_last;

    assign load     = !r_valid || !i_out_stall;
    assign take     = load && !i_q_empty;
    assign n_flush  = i_head.run ? vzre_pkg::ZCNT_W'(1) : i_head.nzeros;
    assign in_flush = (r_idx < n_flush);
    assign o_pop    = take && n_last;

    // Pick the next record of the head command
    always_comb begin
        if (in_flush) begin
            n_kind  = i_head.run ? vzre_pkg::KIND_RUN : vzre_pkg::KIND_PAIR;
            n_value = '0;
            n_color = '0;
            n_len   = i_head.run ? i_head.run_len : '0;
            n_last  = (r_idx == n_flush - 1'b1) && !i_head.pair;
        end else begin
            n_kind  = vzre_pkg::KIND_PAIR;
            n_value = i_head.value;
            n_color = i_head.color;
            n_len   = '0;
            n_last  = 1'b1;
        end
    end

    // Advance the record index within the command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_idx <= n_last ? '0 : r_idx + 1'b1;
            end
            if (load) begin
                r_valid <= !i_q_empty;
            end
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind  <= n_kind;
            r_value <= n_value;
            r_color <= n_color;
            r_len   <= n_len;
            r_last  <= n_last;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_record_kind  = r_kind;
    assign o_out_value    = r_value;
    assign o_out_color    = r_color;
    assign o_run_length   = r_len;
    assign o_last_of_item = r_last;

endmodule

`default_nettype wire

FILE: rtl/voxel_zero_run_encoder_unit.sv
// Top level of the voxel zero-run encoder: front classifier, command queue
// and record expander. Depends on vzre_pkg, vzre_front, vzre_cmd_fifo, vzre_back.
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+------------------------------------------
//   input   | i_in_valid  | o_in_stall  | i_voxel_value, i_voxel_color, i_end_of_chunk
//   output  | o_out_valid | i_out_stall | o_record_kind, o_out_value, o_out_color,
//           |             |             | o_run_length, o_last_of_item
//   config  | i_cfg_wr_en | -           | i_cfg_wr_data
//
// One voxel is taken per cycle while the four-entry command queue has room.
// The back end issues one record per cycle while the output is not stalled, so a
// flush of n short-run zeros plus a pair yields n+1 records; the queue absorbs such bursts.
// The first record of an item passes through the command queue, then the output register.
// Synchronous active-low reset clears the pending count, queue and output valid.
`default_nettype none

module voxel_zero_run_encoder_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [vzre_pkg::MINRUN_W-1:0] i_cfg_wr_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [vzre_pkg::VALUE_W-1:0]  i_voxel_value,
    input  wire logic [vzre_pkg::COLOR_W-1:0]  i_voxel_color,
    input  wire logic                          i_end_of_chunk,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_record_kind,
    output logic [vzre_pkg::VALUE_W-1:0]       o_out_value,
    output logic [vzre_pkg::COLOR_W-1:0]       o_out_color,
    output logic [vzre_pkg::RUN_W-1:0]         o_run_length,
    output logic                               o_last_of_item
);

    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;
    vzre_pkg::t_cmd push_cmd;
    vzre_pkg::t_cmd head_cmd;

    // Classify incoming voxels
    vzre_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .i_voxel_value  (i_voxel_value),
        .i_voxel_color  (i_voxel_color),
        .i_end_of_chunk (i_end_of_chunk),
        .i_q_full       (q_full),
        .o_in_stall     (o_in_stall),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    // Buffer commands
    vzre_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    // Expand commands into records
    vzre_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_head         (head_cmd),
        .o_pop          (pop),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_record_kind  (o_record_kind),
        .o_out_value    (o_out_value),
        .o_out_color    (o_out_color),
        .o_run_length   (o_run_length),
        .o_last_of_item (o_last_of_item)
    );

endmodule

`default_nettype wire
